@@ rtl/nts_pkg.sv @@
// Package for the nearest-target lock and steering block.
// Holds the shared types, register indexes and reset constants.
// Used by every module under rtl but nts_checker.
package nts_pkg;

    localparam int MAX_DET_DEFAULT = 31;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_GATE_DISTANCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_X_DEADBAND    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_DEADBAND    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_YAW_STEP      = 2'd3;

    localparam logic [15:0] GATE_RESET     = 16'd6554;
    localparam logic [15:0] DEADBAND_RESET = 16'd3277;
    localparam logic [12:0] YAW_STEP_RESET = 13'd1024;
    localparam logic [15:0] CENTRE         = 16'd32768;
    localparam logic [15:0] SPEED_OFFSET   = 16'd4096;

    // Lock decision of one frame, passed from the scanner to the steering side.
    typedef struct packed {
        logic        found;
        logic [15:0] h;
        logic [15:0] w;
        logic [15:0] y;
        logic [15:0] x;
    } lock_t;

    typedef struct packed {
        logic [15:0] x_deadband;
        logic [15:0] y_deadband;
        logic [12:0] yaw_step;
    } steer_cfg_t;

endpackage

@@ rtl/nearest_target_lock_steer.sv @@
// Top level of the nearest-target lock and steering block.
// Holds the configuration registers; instantiates nts_front, nts_queue and nts_back.
//
//  Port group   Dir   Moves
//  s_*          in    one detection item; tlast closes the frame
//  m_*          out   one lock/steer item per frame
//  cfg_*        in    register writes, index 0..3
//
// One detection is taken every cycle while the lock queue is not full; the distance
// squares and the compare are combinational in the scanner. A frame's result is
// registered in the lock queue and then in the output register after its tlast item.
// The two-entry lock queue lets the scanner keep running while results stall;
// s_tready drops only when it is full. Reset is asynchronous and needs no clearing pass.
module nearest_target_lock_steer #(
    parameter int MAX_DETECTIONS = nts_pkg::MAX_DET_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,  // center_x, center_y, box_width, box_height
    input  logic [7:0]                     s_tuser,  // class_id
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // target_x, target_y, target_w, target_h, forward_speed, yaw_rate, 2 zero bits
    output logic [95:0]                    m_tdata,
    output logic [0:0]                     m_tuser,  // target_found
    input  logic                           cfg_we,
    input  logic [nts_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [nts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nts_pkg::*;

    logic [15:0] gate_reg;
    steer_cfg_t  steer_reg;
    logic        push, pop, q_full, q_valid;
    lock_t       push_data, q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg             <= GATE_RESET;
            steer_reg.x_deadband <= DEADBAND_RESET;
            steer_reg.y_deadband <= DEADBAND_RESET;
            steer_reg.yaw_step   <= YAW_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_GATE_DISTANCE: gate_reg             <= cfg_wdata;
                REG_X_DEADBAND:    steer_reg.x_deadband <= cfg_wdata;
                REG_Y_DEADBAND:    steer_reg.y_deadband <= cfg_wdata;
                REG_YAW_STEP:      steer_reg.yaw_step   <= cfg_wdata[12:0];
                default:           gate_reg             <= gate_reg;
            endcase
        end
    end

    nts_front #(
        .MaxDet (MAX_DETECTIONS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .gate_distance (gate_reg),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    nts_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    nts_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .cfg      (steer_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/nts_front.sv @@
// Detection scanner: nearest gated detection among the leading class-0 items of a frame.
// Depends on nts_pkg; feeds one lock_t per frame into nts_queue.
// Owns the reference point, which moves to each locked target.
module nts_front #(
    parameter int MaxDet = nts_pkg::MAX_DET_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic [7:0]    s_tuser,
    input  logic          s_tlast,
    input  logic [15:0]   gate_distance,
    input  logic          q_full,
    output logic          push,
    output nts_pkg::lock_t push_data
);
    import nts_pkg::*;

    localparam int CntW = $clog2(MaxDet + 1);

    logic [15:0]     ref_x_reg, ref_y_reg;
    logic [32:0]     best_dist_reg;
    logic [63:0]     best_box_reg;
    logic            best_valid_reg;
    logic            scan_open_reg;
    logic [CntW-1:0] seen_reg;
    logic [31:0]     gate_sq;

    logic [15:0] cx, cy, dx, dy;
    logic [31:0] dx_sq, dy_sq;
    logic [32:0] dist_sq;
    logic        accept, candidate, take;

    assign cx = s_tdata[15:0];
    assign cy = s_tdata[31:16];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && s_tlast;

    assign dx      = (cx >= ref_x_reg) ? (cx - ref_x_reg) : (ref_x_reg - cx);
    assign dy      = (cy >= ref_y_reg) ? (cy - ref_y_reg) : (ref_y_reg - cy);
    assign dx_sq   = {16'd0, dx} * {16'd0, dx};
    assign dy_sq   = {16'd0, dy} * {16'd0, dy};
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign gate_sq = {16'd0, gate_distance} * {16'd0, gate_distance};

    assign candidate = scan_open_reg && (s_tuser == 8'd0) && (seen_reg < CntW'(MaxDet));
    assign take      = candidate && (dist_sq < best_dist_reg) && (dist_sq <= {1'b0, gate_sq});

    // The tlast item is scanned in the same cycle as the push, so its own detection may win.
    always_comb
    begin
        push_data.found = best_valid_reg || take;
        if (take)
        begin
            push_data.x = s_tdata[15:0];
            push_data.y = s_tdata[31:16];
            push_data.w = s_tdata[47:32];
            push_data.h = s_tdata[63:48];
        end
        else
        begin
            push_data.x = best_box_reg[15:0];
            push_data.y = best_box_reg[31:16];
            push_data.w = best_box_reg[47:32];
            push_data.h = best_box_reg[63:48];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg      <= CENTRE;
            ref_y_reg      <= CENTRE;
            best_dist_reg  <= '1;
            best_box_reg   <= '0;
            best_valid_reg <= 1'b0;
            scan_open_reg  <= 1'b1;
            seen_reg       <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                if (push_data.found)
                begin
                    ref_x_reg <= push_data.x;
                    ref_y_reg <= push_data.y;
                end
                best_dist_reg  <= '1;
                best_box_reg   <= '0;
                best_valid_reg <= 1'b0;
                scan_open_reg  <= 1'b1;
                seen_reg       <= '0;
            end
            else
            begin
                if (scan_open_reg && !candidate)
                begin
                    scan_open_reg <= 1'b0;
                end
                if (candidate)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
                if (take)
                begin
                    best_dist_reg  <= dist_sq;
                    best_box_reg   <= s_tdata;
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/nts_queue.sv @@
// Short queue of frame lock decisions between scanner and steering.
// Depends on nts_pkg for lock_t and the default depth.
module nts_queue #(
    parameter int Depth = nts_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nts_pkg::lock_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output nts_pkg::lock_t q_data
);
    import nts_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    lock_t           entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full    = (count_reg == CntW'(Depth));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/nts_back.sv @@
// Steering stage: deadband forward and yaw commands from a lock decision.
// Depends on nts_pkg; drives the output register of the result stream.
module nts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  nts_pkg::lock_t     q_data,
    output logic               pop,
    input  nts_pkg::steer_cfg_t cfg,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [95:0]        m_tdata,
    output logic [0:0]         m_tuser
);
    import nts_pkg::*;

    logic signed [17:0] ex, ey, xb, yb;
    logic [16:0]        mag;
    logic [19:0]        mag5;
    logic [15:0]        spd, fwd;
    logic [13:0]        yaw;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic [15:0] held_fwd_reg;
    logic [13:0] held_yaw_reg;
    logic [15:0] fwd_next;
    logic [13:0] yaw_next;

    assign pop = q_valid && (!m_tvalid_reg || m_tready);

    assign ex   = $signed({2'b00, q_data.x}) - $signed({2'b00, CENTRE});
    assign ey   = $signed({2'b00, q_data.y}) - $signed({2'b00, CENTRE});
    assign xb   = $signed({2'b00, cfg.x_deadband});
    assign yb   = $signed({2'b00, cfg.y_deadband});
    assign mag  = ey[17] ? 17'(-ey) : 17'(ey);
    assign mag5 = {1'b0, mag, 2'b00} + {3'b000, mag};
    // |ey| * 5 / 16 plus one unit in Q12.
    assign spd  = 16'(mag5 >> 4) + SPEED_OFFSET;

    always_comb
    begin
        fwd = '0;
        yaw = '0;
        if (ey > yb)
        begin
            fwd = 16'd0 - spd;
        end
        else if (ey < -yb)
        begin
            fwd = spd;
        end
        if (ex > xb)
        begin
            yaw = 14'd0 - {1'b0, cfg.yaw_step};
        end
        else if (ex < -xb)
        begin
            yaw = {1'b0, cfg.yaw_step};
        end
    end

    // A miss repeats the commands held from the last lock.
    assign fwd_next = q_data.found ? fwd : held_fwd_reg;
    assign yaw_next = q_data.found ? yaw : held_yaw_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_tuser_reg <= q_data.found;
            if (q_data.found)
            begin
                m_tdata_reg[63:0] <= {q_data.h, q_data.w, q_data.y, q_data.x};
            end
            else
            begin
                m_tdata_reg[63:0] <= '0;
            end
            m_tdata_reg[95:64] <= {2'b00, yaw_next, fwd_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            held_fwd_reg <= '0;
            held_yaw_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                m_tvalid_reg <= 1'b1;
                held_fwd_reg <= fwd_next;
                held_yaw_reg <= yaw_next;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/nts_checker.sv @@
// Port-level checks for nearest_target_lock_steer, attached by bind.
// Depends only on the result stream ports of the top level.
module nts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    logic signed [15:0] fwd;
    assign fwd = $signed(m_tdata[79:64]);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss reports an empty box.
    a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:0] == 64'd0)
        else $error("miss carries a nonzero box");

    // A nonzero forward command always includes the one-unit offset.
    a_speed_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && fwd != 16'sd0 |-> fwd >= 16'sd4096 || fwd <= -16'sd4096)
        else $error("forward command below its minimum magnitude");

    // Two pad bits above the yaw field stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[95:94] == 2'b00)
        else $error("pad bits set");

endmodule

bind nearest_target_lock_steer nts_checker u_nts_checker (.*);

@@ dv/nearest_target_lock_steer_tb.sv @@
// Self-checking testbench for nearest_target_lock_steer: streams detection frames,
// predicts each frame's lock and steering result and compares it with the output.
// Depends on rtl/nts_pkg.sv and rtl/nearest_target_lock_steer.sv.
module nearest_target_lock_steer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nts_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int MAX_DET      = MAX_DET_DEFAULT;
    localparam int SETTLE       = 6;
    localparam int PHASE_ITEMS  = 180;

    typedef struct {
        bit [7:0]  cls;
        bit [15:0] cx;
        bit [15:0] cy;
        bit [15:0] w;
        bit [15:0] h;
        bit        last;
    } detection_t;

    typedef struct {
        logic        found;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] fwd;
        logic [13:0] yaw;
    } lock_result_t;

    // Tracks the block's scan and steering state and holds the frame results still due.
    class lock_checker;
        bit [15:0]         gate;
        bit [15:0]         xband;
        bit [15:0]         yband;
        bit [12:0]         yaw_step;
        bit [15:0]         ref_x;
        bit [15:0]         ref_y;
        longint unsigned   best_dist;
        bit [15:0]         best_x;
        bit [15:0]         best_y;
        bit [15:0]         best_w;
        bit [15:0]         best_h;
        bit                best_valid;
        bit                scan_open;
        int                seen;
        bit [15:0]         held_fwd;
        bit [13:0]         held_yaw;
        lock_result_t      pending_locks[$];
        int                mismatches;

        function new();
            gate       = GATE_RESET;
            xband      = DEADBAND_RESET;
            yband      = DEADBAND_RESET;
            yaw_step   = YAW_STEP_RESET;
            ref_x      = CENTRE;
            ref_y      = CENTRE;
            held_fwd   = '0;
            held_yaw   = '0;
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            best_dist  = 64'h1_FFFF_FFFF;
            best_x     = '0;
            best_y     = '0;
            best_w     = '0;
            best_h     = '0;
            best_valid = 1'b0;
            scan_open  = 1'b1;
            seen       = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_GATE_DISTANCE: gate     = value;
                REG_X_DEADBAND:    xband    = value;
                REG_Y_DEADBAND:    yband    = value;
                REG_YAW_STEP:      yaw_step = value[12:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_locks.size();
        endfunction

        // Returns 1 when the detection took part in the nearest-target search.
        function bit take_detection(detection_t det);
            longint unsigned dist_sq;
            longint unsigned gate_sq;
            int              dx;
            int              dy;
            int              ex;
            int              ey;
            int              mag;
            int              spd;
            int              fwd;
            int              yaw;
            bit              scanned;
            lock_result_t    res;
            scanned = 1'b0;
            if (scan_open) begin
                if (det.cls != 0 || seen >= MAX_DET) begin
                    scan_open = 1'b0;
                end
                else begin
                    scanned = 1'b1;
                    dx = int'(det.cx) - int'(ref_x);
                    dy = int'(det.cy) - int'(ref_y);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    dist_sq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
                    gate_sq = longint'(gate) * longint'(gate);
                    seen    = seen + 1;
                    // Strict compare keeps the first of equally distant detections.
                    if (dist_sq < best_dist && dist_sq <= gate_sq) begin
                        best_dist  = dist_sq;
                        best_x     = det.cx;
                        best_y     = det.cy;
                        best_w     = det.w;
                        best_h     = det.h;
                        best_valid = 1'b1;
                    end
                end
            end
            if (det.last) begin
                if (best_valid) begin
                    ex  = int'(best_x) - int'(CENTRE);
                    ey  = int'(best_y) - int'(CENTRE);
                    mag = (ey < 0) ? -ey : ey;
                    spd = ((mag * 5) >>> 4) + int'(SPEED_OFFSET);
                    fwd = 0;
                    yaw = 0;
                    if (ey > int'(yband))
                        fwd = -spd;
                    else if (ey < -int'(yband))
                        fwd = spd;
                    if (ex > int'(xband))
                        yaw = -int'(yaw_step);
                    else if (ex < -int'(xband))
                        yaw = int'(yaw_step);
                    held_fwd  = fwd[15:0];
                    held_yaw  = yaw[13:0];
                    ref_x     = best_x;
                    ref_y     = best_y;
                    res.found = 1'b1;
                    res.x     = best_x;
                    res.y     = best_y;
                    res.w     = best_w;
                    res.h     = best_h;
                end
                else begin
                    res.found = 1'b0;
                    res.x     = '0;
                    res.y     = '0;
                    res.w     = '0;
                    res.h     = '0;
                end
                res.fwd = held_fwd;
                res.yaw = held_yaw;
                pending_locks.push_back(res);
                clear_scan();
            end
            return scanned;
        endfunction

        function void check_lock(logic found, logic [95:0] data);
            lock_result_t got;
            lock_result_t want;
            got.found = found;
            got.x     = data[15:0];
            got.y     = data[31:16];
            got.w     = data[47:32];
            got.h     = data[63:48];
            got.fwd   = data[79:64];
            got.yaw   = data[93:80];
            if (pending_locks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with none expected: found=%b x=%h y=%h w=%h h=%h fwd=%h yaw=%h",
                             got.found, got.x, got.y, got.w, got.h, got.fwd, got.yaw);
            end
            else begin
                want = pending_locks.pop_front();
                if (got.found !== want.found || got.x !== want.x || got.y !== want.y ||
                    got.w !== want.w || got.h !== want.h || got.fwd !== want.fwd ||
                    got.yaw !== want.yaw) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: lock mismatch at %0t", $realtime);
                        $display("  expected found=%b x=%h y=%h w=%h h=%h fwd=%h yaw=%h",
                                 want.found, want.x, want.y, want.w, want.h, want.fwd, want.yaw);
                        $display("  actual   found=%b x=%h y=%h w=%h h=%h fwd=%h yaw=%h",
                                 got.found, got.x, got.y, got.w, got.h, got.fwd, got.yaw);
                    end
                end
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;
    logic [7:0]            s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [95:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    lock_checker checker_h = new();
    int          sent_items;
    int          rx_wait  = 0;
    int          rx_count = 0;

    nearest_target_lock_steer #(
        .MAX_DETECTIONS(MAX_DET)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result side: checks every accepted item and may drop m_tready for a random stall
    // after it, with regular stretches of no stalling.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                checker_h.check_lock(m_tuser[0], m_tdata);
                rx_count++;
                rx_wait = (rx_count % 64 < 16) ? 0 : $urandom_range(0, 3);
            end
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic bit [15:0] clamp16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic int band_edge(int band);
        case ($urandom_range(0, 3))
            0: return -band - 1;
            1: return -band;
            2: return band;
            default: return band + 1;
        endcase
    endfunction

    function automatic detection_t make_det(bit [7:0] cls, bit [15:0] cx, bit [15:0] cy,
                                            bit [15:0] w, bit [15:0] h, bit last);
        detection_t d;
        d.cls  = cls;
        d.cx   = cx;
        d.cy   = cy;
        d.w    = w;
        d.h    = h;
        d.last = last;
        return d;
    endfunction

    // Detection placed at an offset from the current reference point.
    function automatic detection_t near_ref(bit [7:0] cls, int dx, int dy,
                                            bit [15:0] w, bit [15:0] h, bit last);
        return make_det(cls, clamp16(int'(checker_h.ref_x) + dx),
                        clamp16(int'(checker_h.ref_y) + dy), w, h, last);
    endfunction

    function automatic bit [15:0] random_size();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic detection_t random_det(bit last, detection_t prev);
        detection_t d;
        int         r;
        int         g;
        g     = int'(checker_h.gate);
        d.cls = ($urandom_range(0, 99) < 88) ? 8'd0 : 8'($urandom_range(1, 255));
        r     = $urandom_range(0, 99);
        if (r < 40) begin
            d.cx = clamp16(int'(checker_h.ref_x) + int'($urandom_range(0, 2 * g)) - g);
            d.cy = clamp16(int'(checker_h.ref_y) + int'($urandom_range(0, 2 * g)) - g);
        end
        else if (r < 50) begin
            d.cx = checker_h.ref_x;
            d.cy = checker_h.ref_y;
        end
        else if (r < 60) begin
            d.cx = prev.cx;
            d.cy = prev.cy;
        end
        else if (r < 67) begin
            // Mirror of the previous detection about the reference: same distance.
            d.cx = clamp16(2 * int'(checker_h.ref_x) - int'(prev.cx));
            d.cy = clamp16(2 * int'(checker_h.ref_y) - int'(prev.cy));
        end
        else if (r < 75) begin
            d.cx = clamp16(int'(CENTRE) + band_edge(int'(checker_h.xband)));
            d.cy = clamp16(int'(CENTRE) + band_edge(int'(checker_h.yband)));
        end
        else if (r < 90) begin
            d.cx = 16'($urandom_range(0, 65535));
            d.cy = 16'($urandom_range(0, 65535));
        end
        else begin
            d.cx = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            d.cy = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
        end
        d.w    = random_size();
        d.h    = random_size();
        d.last = last;
        return d;
    endfunction

    task automatic send_det(detection_t d, bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d.h, d.w, d.cy, d.cx};
        s_tuser  <= d.cls;
        s_tlast  <= d.last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        void'(checker_h.take_detection(d));
        sent_items++;
    endtask

    // Stop sending and wait until every frame result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (checker_h.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] gate, logic [15:0] xband,
                              logic [15:0] yband, logic [15:0] ystep);
        logic [CFG_ADDR_W-1:0] idx[4];
        logic [15:0]           vals[4];
        idx  = '{REG_GATE_DISTANCE, REG_X_DEADBAND, REG_Y_DEADBAND, REG_YAW_STEP};
        vals = '{gate, xband, yband, ystep};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            checker_h.set_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic directed_frames();
        int g;
        g = int'(checker_h.gate);
        // Detection exactly on the reference point, frame of one item.
        send_det(make_det(8'd0, CENTRE, CENTRE, 16'd0, 16'd0, 1'b1), 1'b0);
        // Two equally distant detections: the first one is locked.
        send_det(near_ref(8'd0, 3000, -4000, 16'hFFFF, 16'hFFFF, 1'b0), 1'b0);
        send_det(near_ref(8'd0, -3000, 4000, 16'd1, 16'd2, 1'b0), 1'b0);
        send_det(near_ref(8'd0, 0, 6000, 16'd3, 16'd4, 1'b1), 1'b0);
        // A nonzero class first closes the scan, so the frame misses.
        send_det(near_ref(8'hFF, 0, 0, 16'd5, 16'd6, 1'b0), 1'b0);
        send_det(near_ref(8'd0, 0, 0, 16'd7, 16'd8, 1'b1), 1'b0);
        // Corner detections, both outside the gate.
        send_det(make_det(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0), 1'b1);
        send_det(make_det(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1);
        // Distance equal to the gate is accepted.
        send_det(near_ref(8'd0, g, 0, 16'h00AA, 16'h5500, 1'b0), 1'b1);
        send_det(near_ref(8'd0, 0, -g - 1, 16'd9, 16'd10, 1'b1), 1'b1);
        // Scan closed by a mid-frame class, a near point after it is ignored.
        send_det(near_ref(8'd0, 100, 100, 16'd11, 16'd12, 1'b0), 1'b0);
        send_det(near_ref(8'h7F, 0, 0, 16'd13, 16'd14, 1'b0), 1'b0);
        send_det(near_ref(8'd0, 0, 0, 16'd15, 16'd16, 1'b1), 1'b0);
        // Closing class on the last item itself.
        send_det(near_ref(8'd0, -30000, 30000, 16'd17, 16'd18, 1'b0), 1'b0);
        send_det(near_ref(8'h80, 0, 0, 16'd19, 16'd20, 1'b1), 1'b0);
    endtask

    task automatic random_frame();
        detection_t d;
        detection_t prev;
        int         r;
        int         len;
        bit         quiet;
        r     = $urandom_range(0, 99);
        len   = (r < 70) ? $urandom_range(1, 6) :
                (r < 90) ? $urandom_range(7, 20) : $urandom_range(30, 36);
        quiet = ($urandom_range(0, 3) == 0);
        prev  = near_ref(8'd0, 0, 0, 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < len; i++) begin
            d = random_det(i == len - 1, prev);
            send_det(d, quiet);
            prev = d;
        end
    endtask

    task automatic run_phase(logic [15:0] gate, logic [15:0] xband,
                             logic [15:0] yband, logic [15:0] ystep);
        int start;
        write_regs(gate, xband, yband, ystep);
        start = sent_items;
        while (sent_items - start < PHASE_ITEMS) begin
            random_frame();
            if ($urandom_range(0, 99) < 3)
                drain();
        end
        drain();
    endtask

    initial
    begin
        sent_items = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values are exercised first, without any write.
        directed_frames();
        drain();

        run_phase(GATE_RESET, DEADBAND_RESET, DEADBAND_RESET, 16'(YAW_STEP_RESET));
        run_phase(16'hFFFF, 16'd0, 16'd0, 16'd4096);
        run_phase(16'd0, 16'd32768, 16'd32768, 16'd0);
        run_phase(16'd20000, 16'd1000, 16'd1000, 16'hFFFF);
        repeat (4) begin
            run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end

        if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
            $display("nearest_target_lock_steer verification clean");
        end
        else begin
            $display("nearest_target_lock_steer verification failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("nearest_target_lock_steer verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/nts_pkg.sv
rtl/nts_front.sv
rtl/nts_queue.sv
rtl/nts_back.sv
rtl/nearest_target_lock_steer.sv
rtl/nts_checker.sv
dv/nearest_target_lock_steer_tb.sv
